// ===== sv/ctsd_pkg.sv =====
// Shared types, codes and digit helpers for the clock time-set and display block.
// No dependencies; used by ctsd_core and clock_time_set_and_display.
package ctsd_pkg;

  typedef enum logic [1:0] {
    MODE_RTC  = 2'd0,
    MODE_SET  = 2'd1,
    MODE_UP   = 2'd2,
    MODE_DOWN = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    DIGIT_RUN       = 2'd0,
    DIGIT_MIN_UNITS = 2'd1,
    DIGIT_MIN_TENS  = 2'd2,
    DIGIT_HOURS     = 2'd3
  } digit_e;

  typedef enum logic [3:0] {
    EDIT_RUN       = 4'b0001,
    EDIT_MIN_UNITS = 4'b0010,
    EDIT_MIN_TENS  = 4'b0100,
    EDIT_HOURS     = 4'b1000
  } edit_e;

  typedef enum logic [1:0] {
    LAMP_OFF = 2'd0,
    LAMP_AM  = 2'd1,
    LAMP_PM  = 2'd2
  } lamp_e;

  localparam logic [5:0] MinuteMax    = 6'd59;
  localparam logic [4:0] HourMax      = 5'd23;
  localparam logic [4:0] HourNoon     = 5'd12;
  localparam logic [3:0] UnitsMax     = 4'd9;
  localparam logic [2:0] MinTensMax   = 3'd5;
  localparam logic [7:0] DecimalPoint = 8'd128;
  localparam logic [3:0] BcdDigitMask = 4'h0F;

  localparam logic [6:0] SEG_TABLE [10] = '{
    7'd63, 7'd6, 7'd91, 7'd79, 7'd102, 7'd109, 7'd125, 7'd71, 7'd127, 7'd103
  };

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] rtc_minutes;
    logic [4:0] rtc_hours;
  } in_t;

  typedef struct packed {
    logic [6:0] seg_minute_units;
    logic [6:0] seg_minute_tens;
    logic [7:0] seg_hour_units;
    logic [6:0] seg_hour_tens;
    logic [1:0] am_pm_lamp;
    logic [1:0] editing_digit;
    logic       rtc_write;
    logic [5:0] rtc_hour_bcd;
    logic [6:0] rtc_minute_bcd;
  } out_t;

  function automatic logic [6:0] seg7(input logic [3:0] d);
    logic [6:0] s;
    s = 7'd0;
    if (d <= UnitsMax) begin
      s = SEG_TABLE[d];
    end
    return s;
  endfunction

  // 0..23 -> packed BCD {tens[1:0], units[3:0]}
  function automatic logic [5:0] hour_bcd(input logic [4:0] h);
    logic [1:0] tens;
    logic [4:0] rest;
    if (h >= 5'd20) begin
      tens = 2'd2;
      rest = h - 5'd20;
    end else if (h >= 5'd10) begin
      tens = 2'd1;
      rest = h - 5'd10;
    end else begin
      tens = 2'd0;
      rest = h;
    end
    return {tens, rest[3:0] & BcdDigitMask};
  endfunction

  // 0..59 -> packed BCD {tens[2:0], units[3:0]}
  function automatic logic [6:0] minute_bcd(input logic [5:0] m);
    logic [2:0] tens;
    logic [5:0] rest;
    if (m >= 6'd50) begin
      tens = 3'd5;
      rest = m - 6'd50;
    end else if (m >= 6'd40) begin
      tens = 3'd4;
      rest = m - 6'd40;
    end else if (m >= 6'd30) begin
      tens = 3'd3;
      rest = m - 6'd30;
    end else if (m >= 6'd20) begin
      tens = 3'd2;
      rest = m - 6'd20;
    end else if (m >= 6'd10) begin
      tens = 3'd1;
      rest = m - 6'd10;
    end else begin
      tens = 3'd0;
      rest = m;
    end
    return {tens, rest[3:0] & BcdDigitMask};
  endfunction

endpackage

// ===== sv/ctsd_core.sv =====
// Time digits, edit step and 12/24-hour flag, with the per-request update and
// display encoding. Depends on ctsd_pkg.
module ctsd_core import ctsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  in_t  req_i,
  output out_t res_o
);

  logic [3:0] mu_q, mu_d;
  logic [2:0] mt_q, mt_d;
  logic [4:0] hour_q, hour_d;
  edit_e      edit_q, edit_d;
  logic       twelve_q, twelve_d;

  logic [5:0] rm_sat;
  logic [4:0] rh_sat;
  logic       write;
  logic [4:0] shown;
  logic [5:0] shown_bcd;
  lamp_e      lamp;
  digit_e     digit;

  always_comb begin
    mu_d     = mu_q;
    mt_d     = mt_q;
    hour_d   = hour_q;
    edit_d   = edit_q;
    twelve_d = twelve_q;
    write    = 1'b0;
    rm_sat   = (req_i.rtc_minutes > MinuteMax) ? MinuteMax : req_i.rtc_minutes;
    rh_sat   = (req_i.rtc_hours > HourMax) ? HourMax : req_i.rtc_hours;

    case (mode_e'(req_i.mode))
      MODE_RTC: begin
        if (edit_q == EDIT_RUN) begin
          {mt_d, mu_d} = minute_bcd(rm_sat);
          hour_d       = rh_sat;
        end
      end
      MODE_SET: begin
        case (edit_q)
          EDIT_RUN:       edit_d = EDIT_MIN_UNITS;
          EDIT_MIN_UNITS: edit_d = EDIT_MIN_TENS;
          EDIT_MIN_TENS:  edit_d = EDIT_HOURS;
          EDIT_HOURS: begin
            edit_d = EDIT_RUN;
            write  = 1'b1;
          end
          default:        edit_d = EDIT_RUN;
        endcase
      end
      MODE_UP: begin
        case (edit_q)
          EDIT_MIN_UNITS: mu_d   = (mu_q >= UnitsMax) ? 4'd0 : mu_q + 4'd1;
          EDIT_MIN_TENS:  mt_d   = (mt_q >= MinTensMax) ? 3'd0 : mt_q + 3'd1;
          EDIT_HOURS:     hour_d = (hour_q >= HourMax) ? 5'd0 : hour_q + 5'd1;
          default: ;
        endcase
      end
      MODE_DOWN: begin
        case (edit_q)
          EDIT_RUN:       twelve_d = ~twelve_q;
          EDIT_MIN_UNITS: mu_d = (mu_q == 4'd0 || mu_q > UnitsMax) ? UnitsMax : mu_q - 4'd1;
          EDIT_MIN_TENS:  mt_d = (mt_q == 3'd0 || mt_q > MinTensMax) ? MinTensMax : mt_q - 3'd1;
          EDIT_HOURS:     hour_d = (hour_q == 5'd0) ? HourMax : hour_q - 5'd1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    if (twelve_d) begin
      if (hour_d == 5'd0) begin
        shown = HourNoon;
      end else if (hour_d > HourNoon) begin
        shown = hour_d - HourNoon;
      end else begin
        shown = hour_d;
      end
      lamp = (hour_d < HourNoon) ? LAMP_AM : LAMP_PM;
    end else begin
      shown = hour_d;
      lamp  = LAMP_OFF;
    end
    shown_bcd = hour_bcd(shown);

    case (edit_d)
      EDIT_RUN:       digit = DIGIT_RUN;
      EDIT_MIN_UNITS: digit = DIGIT_MIN_UNITS;
      EDIT_MIN_TENS:  digit = DIGIT_MIN_TENS;
      EDIT_HOURS:     digit = DIGIT_HOURS;
      default:        digit = DIGIT_RUN;
    endcase

    res_o.seg_minute_units = seg7(mu_d);
    res_o.seg_minute_tens  = seg7({1'b0, mt_d});
    res_o.seg_hour_units   = DecimalPoint | {1'b0, seg7(shown_bcd[3:0])};
    res_o.seg_hour_tens    = seg7({2'b00, shown_bcd[5:4]});
    res_o.am_pm_lamp       = lamp;
    res_o.editing_digit    = digit;
    res_o.rtc_write        = write;
    res_o.rtc_hour_bcd     = write ? hour_bcd(hour_q) : 6'd0;
    res_o.rtc_minute_bcd   = write ? {mt_q, mu_q} : 7'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q     <= 4'd0;
      mt_q     <= 3'd0;
      hour_q   <= HourNoon;
      edit_q   <= EDIT_RUN;
      twelve_q <= 1'b0;
    end else if (adv_i) begin
      mu_q     <= mu_d;
      mt_q     <= mt_d;
      hour_q   <= hour_d;
      edit_q   <= edit_d;
      twelve_q <= twelve_d;
    end
  end

  a_digits_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mu_q <= UnitsMax && mt_q <= MinTensMax && hour_q <= HourMax)
    else $error("time digit out of range");

  a_commit_returns_to_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && req_i.mode == MODE_SET && edit_q == EDIT_HOURS |=> edit_q == EDIT_RUN)
    else $error("commit did not return to running");

  a_rtc_ignored_while_editing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && req_i.mode == MODE_RTC && edit_q != EDIT_RUN
    |=> $stable(mu_q) && $stable(mt_q) && $stable(hour_q))
    else $error("clock update changed digits during edit");

  a_write_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.rtc_write |-> edit_q == EDIT_HOURS && res_o.editing_digit == DIGIT_RUN)
    else $error("clock write outside commit");

endmodule

// ===== sv/clock_time_set_and_display.sv =====
// Clock time-set and display controller: top level with request and result registers.
// Depends on ctsd_pkg and ctsd_core.
//
// Each accepted request (clock update, set, up or down) yields exactly one result
// showing the display after the event; it passes through the request register, then
// the result register. A new request is taken every cycle;
// the rate drops only while the result register is held by out_stall_i, and the
// request register then holds one more request before in_stall_o rises.
module clock_time_set_and_display import ctsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_res_o
);

  logic s1_valid_q;
  in_t  s1_req_q;
  logic out_valid_q;
  out_t out_res_q;
  logic adv;
  out_t core_res;

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;

  ctsd_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .req_i (s1_req_q),
    .res_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_req_q <= in_req_i;
    end
    if (adv) begin
      out_res_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

// ===== dv/tb_clock_time_set_and_display.sv =====
// Self-checking testbench for clock_time_set_and_display: directed rows, then random
// edit sessions and noise, with random idling and stalls on both channels.
// Depends on ctsd_pkg and the clock_time_set_and_display RTL.
module tb_clock_time_set_and_display;
  import ctsd_pkg::*;

  localparam int unsigned RandomRequests = 2000;
  localparam int unsigned IdlePercent    = 28;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned CalmFirst      = 900;
  localparam int unsigned CalmLast       = 1300;
  localparam int unsigned HoldAtResult   = 300;
  localparam int unsigned HoldCycles     = 60;
  localparam int unsigned PauseAtRequest = 1500;
  localparam int unsigned DrainCycles    = 6;
  localparam int unsigned PrintLimit     = 30;

  localparam logic [6:0] SEGMENT_CODE [10] = '{
    7'd63, 7'd6, 7'd91, 7'd79, 7'd102, 7'd109, 7'd125, 7'd71, 7'd127, 7'd103
  };

  typedef struct packed {
    in_t  req;
    logic pinned;
    out_t view;
  } stim_row_t;

  localparam out_t NO_VIEW = '0;
  localparam int unsigned NumRows = 23;

  localparam stim_row_t STIM_ROWS [NumRows] = '{
    '{'{MODE_UP,   6'd0,  5'd0},  1'b1,
      '{7'd63, 7'd63, 8'd219, 7'd6, LAMP_OFF, DIGIT_RUN, 1'b0, 6'd0, 7'd0}},
    '{'{MODE_RTC,  6'd59, 5'd23}, 1'b1,
      '{7'd103, 7'd109, 8'd207, 7'd91, LAMP_OFF, DIGIT_RUN, 1'b0, 6'd0, 7'd0}},
    '{'{MODE_RTC,  6'd63, 5'd31}, 1'b1,
      '{7'd103, 7'd109, 8'd207, 7'd91, LAMP_OFF, DIGIT_RUN, 1'b0, 6'd0, 7'd0}},
    '{'{MODE_RTC,  6'd0,  5'd0},  1'b1,
      '{7'd63, 7'd63, 8'd191, 7'd63, LAMP_OFF, DIGIT_RUN, 1'b0, 6'd0, 7'd0}},
    '{'{MODE_DOWN, 6'd0,  5'd0},  1'b1,
      '{7'd63, 7'd63, 8'd219, 7'd6, LAMP_AM, DIGIT_RUN, 1'b0, 6'd0, 7'd0}},
    '{'{MODE_RTC,  6'd0,  5'd12}, 1'b0, NO_VIEW},
    '{'{MODE_RTC,  6'd45, 5'd13}, 1'b0, NO_VIEW},
    '{'{MODE_RTC,  6'd0,  5'd23}, 1'b0, NO_VIEW},
    '{'{MODE_SET,  6'd0,  5'd0},  1'b0, NO_VIEW},
    '{'{MODE_RTC,  6'd10, 5'd5},  1'b0, NO_VIEW},
    '{'{MODE_DOWN, 6'd0,  5'd0},  1'b0, NO_VIEW},
    '{'{MODE_UP,   6'd0,  5'd0},  1'b0, NO_VIEW},
    '{'{MODE_UP,   6'd0,  5'd0},  1'b0, NO_VIEW},
    '{'{MODE_SET,  6'd0,  5'd0},  1'b0, NO_VIEW},
    '{'{MODE_DOWN, 6'd0,  5'd0},  1'b0, NO_VIEW},
    '{'{MODE_UP,   6'd0,  5'd0},  1'b0, NO_VIEW},
    '{'{MODE_SET,  6'd0,  5'd0},  1'b0, NO_VIEW},
    '{'{MODE_UP,   6'd0,  5'd0},  1'b0, NO_VIEW},
    '{'{MODE_DOWN, 6'd0,  5'd0},  1'b0, NO_VIEW},
    '{'{MODE_DOWN, 6'd0,  5'd0},  1'b0, NO_VIEW},
    '{'{MODE_SET,  6'd0,  5'd0},  1'b1,
      '{7'd6, 7'd63, 8'd191, 7'd6, LAMP_PM, DIGIT_RUN, 1'b1, 6'h22, 7'h01}},
    '{'{MODE_DOWN, 6'd0,  5'd0},  1'b0, NO_VIEW},
    '{'{MODE_UP,   6'd0,  5'd0},  1'b0, NO_VIEW}
  };

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  in_t  in_req = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  out_t out_res_o;

  logic [3:0] clk_min_units;
  logic [2:0] clk_min_tens;
  logic [3:0] clk_hour_units;
  logic [1:0] clk_hour_tens;
  digit_e     clk_step;
  logic       clk_twelve;

  out_t        display_q [$];
  int unsigned requests_sent   = 0;
  int unsigned results_checked = 0;
  int unsigned commits_seen    = 0;
  int unsigned twelve_hour_seen = 0;
  int unsigned mismatches      = 0;
  int unsigned stuck_cycles    = 0;

  clock_time_set_and_display i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_res_o  (out_res_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void load_hour(input int hrs);
    clk_hour_tens  = 2'(hrs / 10);
    clk_hour_units = 4'(hrs % 10);
  endfunction

  function automatic void nudge_digit(input logic up);
    int hrs;
    case (clk_step)
      DIGIT_MIN_UNITS: begin
        if (up) clk_min_units = (clk_min_units >= 4'd9) ? 4'd0 : clk_min_units + 4'd1;
        else clk_min_units = (clk_min_units == 4'd0 || clk_min_units > 4'd9) ? 4'd9
                                                                             : clk_min_units - 4'd1;
      end
      DIGIT_MIN_TENS: begin
        if (up) clk_min_tens = (clk_min_tens >= 3'd5) ? 3'd0 : clk_min_tens + 3'd1;
        else clk_min_tens = (clk_min_tens == 3'd0 || clk_min_tens > 3'd5) ? 3'd5
                                                                          : clk_min_tens - 3'd1;
      end
      DIGIT_HOURS: begin
        hrs = int'(clk_hour_tens) * 10 + int'(clk_hour_units);
        if (hrs > 23) hrs = 23;
        if (up) hrs = (hrs == 23) ? 0 : hrs + 1;
        else hrs = (hrs == 0) ? 23 : hrs - 1;
        load_hour(hrs);
      end
      default: ;
    endcase
  endfunction

  function automatic out_t advance_clock(input in_t req);
    out_t res;
    int   mins;
    int   hrs;
    int   shown;
    res = '0;
    case (req.mode)
      MODE_RTC: begin
        if (clk_step == DIGIT_RUN) begin
          mins = (req.rtc_minutes > 6'd59) ? 59 : int'(req.rtc_minutes);
          hrs  = (req.rtc_hours > 5'd23) ? 23 : int'(req.rtc_hours);
          clk_min_units = 4'(mins % 10);
          clk_min_tens  = 3'(mins / 10);
          load_hour(hrs);
        end
      end
      MODE_SET: begin
        if (clk_step == DIGIT_HOURS) begin
          clk_step           = DIGIT_RUN;
          res.rtc_write      = 1'b1;
          res.rtc_hour_bcd   = {clk_hour_tens, clk_hour_units};
          res.rtc_minute_bcd = {clk_min_tens, clk_min_units};
        end else begin
          clk_step = digit_e'(clk_step + 2'd1);
        end
      end
      MODE_UP: begin
        if (clk_step != DIGIT_RUN) nudge_digit(1'b1);
      end
      default: begin
        if (clk_step == DIGIT_RUN) clk_twelve = ~clk_twelve;
        else nudge_digit(1'b0);
      end
    endcase

    hrs = int'(clk_hour_tens) * 10 + int'(clk_hour_units);
    if (clk_twelve) begin
      shown = (hrs == 0) ? 12 : (hrs > 12) ? hrs - 12 : hrs;
      res.am_pm_lamp = (hrs < 12) ? LAMP_AM : LAMP_PM;
    end else begin
      shown = hrs;
      res.am_pm_lamp = LAMP_OFF;
    end
    res.seg_minute_units = SEGMENT_CODE[clk_min_units];
    res.seg_minute_tens  = SEGMENT_CODE[clk_min_tens];
    res.seg_hour_units   = {1'b1, SEGMENT_CODE[shown % 10]};
    res.seg_hour_tens    = SEGMENT_CODE[shown / 10];
    res.editing_digit    = clk_step;
    return res;
  endfunction

  function automatic in_t random_request(input mode_e mode);
    in_t req;
    req.mode = mode;
    if ($urandom_range(99) < 85) begin
      req.rtc_minutes = 6'($urandom_range(59));
      req.rtc_hours   = 5'($urandom_range(23));
    end else begin
      req.rtc_minutes = 6'($urandom_range(63));
      req.rtc_hours   = 5'($urandom_range(31));
    end
    return req;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatches < PrintLimit) begin
      $display("mismatch at result %0d: %s got %h want %h", results_checked, what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_display(input out_t got);
    out_t want;
    if (display_q.size() == 0) begin
      report_mismatch("unexpected result", '0, '0);
      return;
    end
    want = display_q.pop_front();
    if (got.seg_minute_units !== want.seg_minute_units)
      report_mismatch("seg_minute_units", 8'(got.seg_minute_units), 8'(want.seg_minute_units));
    if (got.seg_minute_tens !== want.seg_minute_tens)
      report_mismatch("seg_minute_tens", 8'(got.seg_minute_tens), 8'(want.seg_minute_tens));
    if (got.seg_hour_units !== want.seg_hour_units)
      report_mismatch("seg_hour_units", got.seg_hour_units, want.seg_hour_units);
    if (got.seg_hour_tens !== want.seg_hour_tens)
      report_mismatch("seg_hour_tens", 8'(got.seg_hour_tens), 8'(want.seg_hour_tens));
    if (got.am_pm_lamp !== want.am_pm_lamp)
      report_mismatch("am_pm_lamp", 8'(got.am_pm_lamp), 8'(want.am_pm_lamp));
    if (got.editing_digit !== want.editing_digit)
      report_mismatch("editing_digit", 8'(got.editing_digit), 8'(want.editing_digit));
    if (got.rtc_write !== want.rtc_write)
      report_mismatch("rtc_write", 8'(got.rtc_write), 8'(want.rtc_write));
    if (got.rtc_hour_bcd !== want.rtc_hour_bcd)
      report_mismatch("rtc_hour_bcd", 8'(got.rtc_hour_bcd), 8'(want.rtc_hour_bcd));
    if (got.rtc_minute_bcd !== want.rtc_minute_bcd)
      report_mismatch("rtc_minute_bcd", 8'(got.rtc_minute_bcd), 8'(want.rtc_minute_bcd));
    if (want.rtc_write) commits_seen++;
    if (want.am_pm_lamp != LAMP_OFF) twelve_hour_seen++;
    results_checked++;
  endtask

  task automatic offer_request(input in_t req, input logic pinned, input out_t view);
    out_t predicted;
    logic calm;
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = advance_clock(req);
    display_q.push_back(pinned ? view : predicted);
    requests_sent++;
    calm = (requests_sent >= CalmFirst && requests_sent < CalmLast);
    if (!calm && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic run_edit_session();
    int unsigned turns;
    in_t req;
    offer_request(random_request(MODE_SET), 1'b0, NO_VIEW);
    repeat (3) begin
      turns = $urandom_range(6);
      repeat (turns) begin
        if ($urandom_range(7) == 0) req = random_request(MODE_RTC);
        else req = random_request($urandom_range(1) ? MODE_UP : MODE_DOWN);
        offer_request(req, 1'b0, NO_VIEW);
      end
      offer_request(random_request(MODE_SET), 1'b0, NO_VIEW);
    end
  endtask

  // Receiver: check accepted results, stall at random, hold off once for a long stretch.
  always @(posedge clk_i) begin
    int unsigned hold_left;
    bit          held;
    logic        calm;
    if (rst_n && out_valid_o && !out_stall) begin
      check_display(out_res_o);
      if (results_checked == HoldAtResult && !held) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
    end
    calm = (results_checked >= CalmFirst && results_checked < CalmLast);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IdlePercent);
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WatchdogLimit) begin
        $display("watchdog: no request or result moved for %0d cycles", stuck_cycles);
        $display("tb: failure");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    logic paused;
    paused         = 1'b0;
    clk_min_units  = 4'd0;
    clk_min_tens   = 3'd0;
    clk_hour_units = 4'd2;
    clk_hour_tens  = 2'd1;
    clk_step       = DIGIT_RUN;
    clk_twelve     = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (STIM_ROWS[i]) begin
      offer_request(STIM_ROWS[i].req, STIM_ROWS[i].pinned, STIM_ROWS[i].view);
    end

    while (requests_sent < NumRows + RandomRequests) begin
      if (!paused && requests_sent >= PauseAtRequest) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        while (display_q.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(99) < 65) begin
        run_edit_session();
      end else begin
        offer_request(random_request(mode_e'($urandom_range(3))), 1'b0, NO_VIEW);
      end
    end

    in_valid <= 1'b0;
    while (display_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("summary: %0d requests sent, %0d results checked, %0d mismatches",
             requests_sent, results_checked, mismatches);
    $display("summary: %0d time commits to the clock chip, %0d results in 12-hour format",
             commits_seen, twelve_hour_seen);
    if (mismatches == 0 && display_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ctsd_pkg.sv
sv/ctsd_core.sv
sv/clock_time_set_and_display.sv
dv/tb_clock_time_set_and_display.sv
